FILE: sv/sess_pkg.sv
// ----------------------------------------------------------------------------
// Session table package
// Shared payload types, command and feedback structs, codes and constants.
// ----------------------------------------------------------------------------
package sess_pkg;

  // Widest slot index carried between front and back (64 slots max)
  localparam int IDX_W_MAX = 6;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Idle limit after reset, in seconds
  localparam logic [31:0] IDLE_LIMIT_RESET = 32'd3600;

  // Request codes
  localparam logic [2:0] REQ_CREATE   = 3'd0;
  localparam logic [2:0] REQ_REINSERT = 3'd1;
  localparam logic [2:0] REQ_LOOKUP   = 3'd2;
  localparam logic [2:0] REQ_REMOVE   = 3'd3;
  localparam logic [2:0] REQ_REAP     = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_QUOTA       = 3'd1;
  localparam logic [2:0] ST_EXISTS      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_REAPED      = 3'd4;
  localparam logic [2:0] ST_NONE_REAPED = 3'd5;

  // Input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] session_key;
    logic [15:0] session_handle;
    logic        read_only_in;
    logic [31:0] now_seconds;
  } req_t;

  // Output beat
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [63:0] key_out;
    logic [15:0] handle_out;
    logic        read_only_out;
    logic        last_of_run;
  } res_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_QUOTA,
    OP_NOT_FOUND,
    OP_EXISTS,
    OP_CREATE,
    OP_LOOKUP,
    OP_REMOVE,
    OP_REAP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [IDX_W_MAX-1:0] idx;
    logic [63:0]          key;
    logic [15:0]          handle;
    logic                 ro;
    logic [31:0]          now;
  } cmd_t;

  // Back-to-front feedback during a reap walk
  typedef struct packed {
    logic                 clr_valid;
    logic [IDX_W_MAX-1:0] clr_idx;
    logic                 reap_done;
  } fb_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_REAP_RD,
    BK_REAP_CHK,
    BK_REAP_END
  } back_state_t;

endpackage

FILE: sv/sess_front.sv
// ----------------------------------------------------------------------------
// Session table front end
// Accepts request beats, matches keys against the slot CAM, picks the lowest
// free slot and queues a classified command. Owns the slot-used bits.
// ----------------------------------------------------------------------------
module sess_front #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sess_pkg::req_t in_data,
  output logic           q_push,
  output sess_pkg::cmd_t q_cmd,
  input  logic           q_full,
  input  sess_pkg::fb_t  fb,
  output logic [SLOTS-1:0] used
);
  import sess_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [KEY_BITS-1:0] key_q [SLOTS];
  logic                reap_busy;
  logic [KEY_BITS-1:0] key_m;
  logic [SLOTS-1:0]    hit;
  logic                hit_any;
  logic                free_any;
  logic [IW-1:0]       hit_idx;
  logic [IW-1:0]       free_idx;
  logic                accept;
  logic                alloc;
  logic                free_en;

  assign key_m    = KEY_BITS'(in_data.session_key);
  assign in_stall = q_full || reap_busy;
  assign accept   = in_valid && !in_stall;

  // Parallel key compare, one comparator per slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = used[i] && (key_q[i] == key_m);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!used[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Request classification
  always_comb begin
    q_cmd.op     = OP_QUOTA;
    q_cmd.idx    = '0;
    q_cmd.key    = in_data.session_key;
    q_cmd.handle = in_data.session_handle;
    q_cmd.ro     = in_data.read_only_in;
    q_cmd.now    = in_data.now_seconds;
    q_push       = 1'b0;
    alloc        = 1'b0;
    free_en      = 1'b0;
    unique case (in_data.req_type) inside
      REQ_CREATE, REQ_REINSERT: begin
        q_push = accept;
        if ((in_data.req_type == REQ_REINSERT) && hit_any) begin
          q_cmd.op  = OP_EXISTS;
          q_cmd.idx = IDX_W_MAX'(hit_idx);
        end else if (free_any) begin
          q_cmd.op  = OP_CREATE;
          q_cmd.idx = IDX_W_MAX'(free_idx);
          alloc     = accept;
          if (in_data.req_type == REQ_REINSERT) begin
            q_cmd.ro = 1'b0;
          end
        end
      end
      REQ_LOOKUP: begin
        q_push    = accept;
        q_cmd.op  = hit_any ? OP_LOOKUP : OP_NOT_FOUND;
        q_cmd.idx = hit_any ? IDX_W_MAX'(hit_idx) : '0;
      end
      REQ_REMOVE: begin
        q_push    = accept;
        q_cmd.op  = hit_any ? OP_REMOVE : OP_NOT_FOUND;
        q_cmd.idx = hit_any ? IDX_W_MAX'(hit_idx) : '0;
        free_en   = accept && hit_any;
      end
      REQ_REAP: begin
        q_push   = accept;
        q_cmd.op = OP_REAP;
      end
      default: begin
        // unused request codes are taken and dropped
      end
    endcase
  end

  // Slot-used bits and reap blocking
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      reap_busy <= 1'b0;
    end else begin
      if (alloc) begin
        used[free_idx] <= 1'b1;
      end
      if (free_en) begin
        used[hit_idx] <= 1'b0;
      end
      if (fb.clr_valid) begin
        used[fb.clr_idx[IW-1:0]] <= 1'b0;
      end
      if (q_push && (q_cmd.op == OP_REAP)) begin
        reap_busy <= 1'b1;
      end else if (fb.reap_done) begin
        reap_busy <= 1'b0;
      end
    end
  end

  // Key CAM entries
  always_ff @(posedge clk) begin
    if (alloc) begin
      key_q[free_idx] <= key_m;
    end
  end

endmodule

FILE: sv/sess_queue.sv
// ----------------------------------------------------------------------------
// Session table command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module sess_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sess_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  output sess_pkg::cmd_t head,
  input  logic           pop
);
  import sess_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          ent [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign full  = (cnt == CW'(QUEUE_DEPTH));
  assign valid = (cnt != '0);
  assign head  = ent[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= push_cmd;
    end
  end

endmodule

FILE: sv/sess_back.sv
// ----------------------------------------------------------------------------
// Session table back end
// Executes queued commands against the slot data and activity-time memories,
// walks the slots for a reap and drives the registered result beat.
// ----------------------------------------------------------------------------
module sess_back #(
  parameter int SLOTS       = 16,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             q_valid,
  input  sess_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  input  logic [SLOTS-1:0] used,
  output sess_pkg::fb_t    fb,
  output logic             out_valid,
  input  logic             out_stall,
  output sess_pkg::res_t   out_data
);
  import sess_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Slot memories
  logic [KEY_BITS-1:0]    key_mem  [SLOTS];
  logic [HANDLE_BITS-1:0] hnd_mem  [SLOTS];
  logic                   ro_mem   [SLOTS];
  logic [31:0]            time_mem [SLOTS];

  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_hnd;
  logic                   rd_ro;
  logic [31:0]            rd_time;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          wr_idx;
  logic [KEY_BITS-1:0]    wr_key;
  logic [HANDLE_BITS-1:0] wr_hnd;
  logic                   wr_en;
  logic                   tw_en;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cmd;
  logic [31:0] limit;
  logic [IW-1:0] slot;
  logic        slot_last;
  logic        held_valid;
  res_t        held_res;
  logic        held_load;
  logic        walk_clr;
  logic        walk_inc;
  logic        expired;
  logic        chk_go;
  logic        out_free;
  logic        push;
  res_t        res;

  function automatic res_t make_res(logic [2:0] st, logic [IW-1:0] idx,
                                    logic [KEY_BITS-1:0] k, logic [HANDLE_BITS-1:0] h,
                                    logic ro, logic last);
    res_t        r;
    logic [7:0]  ix8;
    logic [31:0] h32;
    ix8             = 8'(idx);
    h32             = 32'(h);
    r.status        = st;
    r.slot_index    = ix8[3:0];
    r.key_out       = 64'(k);
    r.handle_out    = h32[15:0];
    r.read_only_out = ro;
    r.last_of_run   = last;
    return r;
  endfunction

  assign wr_idx    = q_cmd.idx[IW-1:0];
  assign wr_key    = KEY_BITS'(q_cmd.key);
  assign wr_hnd    = HANDLE_BITS'(q_cmd.handle);
  assign out_free  = !out_valid || !out_stall;
  assign slot_last = (slot == IW'(SLOTS - 1));
  // idle time wraps modulo 2^32
  assign expired   = used[slot] && ((cmd.now - rd_time) >= limit);
  assign chk_go    = !expired || !held_valid || out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_EXISTS, OP_LOOKUP, OP_REMOVE: state_next = BK_READ;
            OP_REAP:                         state_next = BK_REAP_RD;
            default:                         state_next = BK_IDLE;
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_REAP_RD: begin
        state_next = BK_REAP_CHK;
      end
      BK_REAP_CHK: begin
        if (chk_go) begin
          state_next = slot_last ? BK_REAP_END : BK_REAP_RD;
        end
      end
      BK_REAP_END: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    push      = 1'b0;
    res       = make_res(ST_OK, '0, '0, '0, 1'b0, 1'b1);
    wr_en     = 1'b0;
    tw_en     = 1'b0;
    rd_addr   = cmd.idx[IW-1:0];
    fb        = '0;
    held_load = 1'b0;
    walk_clr  = 1'b0;
    walk_inc  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        rd_addr = q_cmd.idx[IW-1:0];
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_QUOTA: begin
              q_pop = out_free;
              push  = out_free;
              res   = make_res(ST_QUOTA, '0, '0, '0, 1'b0, 1'b1);
            end
            OP_NOT_FOUND: begin
              q_pop = out_free;
              push  = out_free;
              res   = make_res(ST_NOT_FOUND, '0, '0, '0, 1'b0, 1'b1);
            end
            OP_CREATE: begin
              q_pop = out_free;
              push  = out_free;
              wr_en = out_free;
              tw_en = out_free;
              res   = make_res(ST_OK, wr_idx, wr_key, wr_hnd, q_cmd.ro, 1'b1);
            end
            OP_EXISTS, OP_REMOVE: begin
              q_pop = 1'b1;
            end
            OP_LOOKUP: begin
              q_pop = 1'b1;
              tw_en = 1'b1;
            end
            OP_REAP: begin
              q_pop    = 1'b1;
              walk_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        push = out_free;
        res  = make_res((cmd.op == OP_EXISTS) ? ST_EXISTS : ST_OK, cmd.idx[IW-1:0],
                        rd_key, rd_hnd, rd_ro, 1'b1);
      end
      BK_REAP_RD: begin
        rd_addr = slot;
      end
      BK_REAP_CHK: begin
        rd_addr = slot;
        if (chk_go) begin
          walk_inc = 1'b1;
          if (expired) begin
            // previous reaped slot goes out, this one is held back
            push         = held_valid;
            res          = held_res;
            held_load    = 1'b1;
            fb.clr_valid = 1'b1;
            fb.clr_idx   = IDX_W_MAX'(slot);
          end
        end
      end
      BK_REAP_END: begin
        push         = out_free;
        fb.reap_done = out_free;
        if (held_valid) begin
          res             = held_res;
          res.last_of_run = 1'b1;
        end else begin
          res = make_res(ST_NONE_REAPED, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      held_valid <= 1'b0;
      slot       <= '0;
      limit      <= IDLE_LIMIT_RESET;
    end else begin
      state <= state_next;
      if (walk_clr) begin
        slot       <= '0;
        held_valid <= 1'b0;
      end else begin
        if (walk_inc) begin
          slot <= slot + 1'b1;
        end
        if (held_load) begin
          held_valid <= 1'b1;
        end
      end
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
    end
  end

  // Command and held-result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (held_load) begin
      held_res <= make_res(ST_REAPED, slot, rd_key, rd_hnd, rd_ro, 1'b0);
    end
  end

  // Slot memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
      hnd_mem[wr_idx] <= wr_hnd;
      ro_mem[wr_idx]  <= q_cmd.ro;
    end
    if (tw_en) begin
      time_mem[wr_idx] <= q_cmd.now;
    end
    rd_key  <= key_mem[rd_addr];
    rd_hnd  <= hnd_mem[rd_addr];
    rd_ro   <= ro_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= res;
    end
  end

endmodule

FILE: sv/session_table_with_idle_aging.sv
// ----------------------------------------------------------------------------
// Session table with idle aging
// Slot table of secret keys with create, reinsert, lookup, remove and reap.
// ----------------------------------------------------------------------------
// The front end matches the key against all slots in parallel and queues a
// classified command; the back end retires it against the slot memories.
// Create, quota-exceeded and not-found results go from the queue head straight
// into the result register; reinsert-exists, lookup and remove first need a
// registered memory read. The input keeps taking requests while the command
// queue has room and no reap is running. Reap walks every slot, reading and
// then checking each one, can be held by output stalls, and the input stalls
// until the walk ends. Reaped results come in ascending slot order with
// last_of_run on the final one. Unused request codes are taken and give no
// result. The idle limit resets to 3600 s.
module session_table_with_idle_aging #(
  parameter int SLOTS       = 16,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sess_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sess_pkg::res_t out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import sess_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             q_push;
  cmd_t             q_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             q_head;
  logic             q_pop;
  fb_t              fb;
  logic [SLOTS-1:0] used;

  sess_front #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .q_full   (q_full),
    .fb       (fb),
    .used     (used)
  );

  sess_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  sess_back #(
    .SLOTS       (SLOTS),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .used      (used),
    .fb        (fb),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a queued reap blocks the input until the walk finishes
  a_reap_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_push && (q_cmd.op == OP_REAP)) |=> in_stall)
    else $error("input not stalled behind a reap");

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // reap only frees slots that are in use
  a_reap_frees_used: assert property (@(posedge clk) disable iff (rst)
    fb.clr_valid |-> used[fb.clr_idx[IW-1:0]])
    else $error("reap freed an unused slot");

  // only reaped beats may carry a cleared last flag
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != ST_REAPED)) |-> out_data.last_of_run)
    else $error("single-result beat without last_of_run");
`endif

endmodule

FILE: tb/sv/session_table_with_idle_aging_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session table checker
// Watches the request, result and idle-limit ports, keeps a shadow copy of
// the slot table, and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module session_table_with_idle_aging_checker #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  sess_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  sess_pkg::res_t out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  output int             fail_count,
  output int             pending,
  output int             beats_checked,
  output int             beats_reaped
);
  import sess_pkg::*;

  // Shadow slot table
  logic        live      [SLOTS];
  logic [63:0] tab_key   [SLOTS];
  logic [15:0] tab_handle[SLOTS];
  logic        tab_ro    [SLOTS];
  logic [31:0] tab_stamp [SLOTS];
  logic [31:0] idle_limit;

  // Results still owed by the block, oldest first
  res_t results_due[$];

  // Lowest used slot holding the key, -1 when absent
  function automatic int match_slot(input logic [63:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (live[i] && tab_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Lowest free slot, -1 when the table is full
  function automatic int spare_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!live[i]) return i;
    end
    return -1;
  endfunction

  // Result beat for a slot, or all data zero when slot is -1
  function automatic res_t slot_result(input logic [2:0] status, input int slot,
                                       input logic last);
    res_t beat;
    beat = '0;
    beat.status      = status;
    beat.last_of_run = last;
    if (slot >= 0) begin
      beat.slot_index    = 4'(slot);
      beat.key_out       = tab_key[slot];
      beat.handle_out    = tab_handle[slot];
      beat.read_only_out = tab_ro[slot];
    end
    return beat;
  endfunction

  // Work out the results of one accepted request and update the shadow table
  task automatic predict_request(input req_t rq);
    int   hit;
    int   spare;
    res_t held;
    bit   have_held;
    have_held = 1'b0;
    held      = '0;
    case (rq.req_type)
      REQ_CREATE, REQ_REINSERT: begin
        hit = (rq.req_type == REQ_REINSERT) ? match_slot(rq.session_key) : -1;
        if (hit >= 0) begin
          results_due.push_back(slot_result(ST_EXISTS, hit, 1'b1));
        end else begin
          spare = spare_slot();
          if (spare < 0) begin
            results_due.push_back(slot_result(ST_QUOTA, -1, 1'b1));
          end else begin
            live[spare]       = 1'b1;
            tab_key[spare]    = rq.session_key;
            tab_handle[spare] = rq.session_handle;
            tab_ro[spare]     = (rq.req_type == REQ_CREATE) ? rq.read_only_in : 1'b0;
            tab_stamp[spare]  = rq.now_seconds;
            results_due.push_back(slot_result(ST_OK, spare, 1'b1));
          end
        end
      end
      REQ_LOOKUP: begin
        hit = match_slot(rq.session_key);
        if (hit < 0) begin
          results_due.push_back(slot_result(ST_NOT_FOUND, -1, 1'b1));
        end else begin
          tab_stamp[hit] = rq.now_seconds;
          results_due.push_back(slot_result(ST_OK, hit, 1'b1));
        end
      end
      REQ_REMOVE: begin
        hit = match_slot(rq.session_key);
        if (hit < 0) begin
          results_due.push_back(slot_result(ST_NOT_FOUND, -1, 1'b1));
        end else begin
          results_due.push_back(slot_result(ST_OK, hit, 1'b1));
          live[hit]   = 1'b0;
          tab_ro[hit] = 1'b0;
        end
      end
      REQ_REAP: begin
        // age wraps mod 2^32; hold one beat back so the last gets the flag
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && (rq.now_seconds - tab_stamp[i]) >= idle_limit) begin
            if (have_held) results_due.push_back(held);
            held      = slot_result(ST_REAPED, i, 1'b0);
            have_held = 1'b1;
            live[i]   = 1'b0;
            tab_ro[i] = 1'b0;
          end
        end
        if (have_held) begin
          held.last_of_run = 1'b1;
          results_due.push_back(held);
        end else begin
          results_due.push_back(slot_result(ST_NONE_REAPED, -1, 1'b1));
        end
      end
      default: ;  // unused codes give no result
    endcase
  endtask

  // Compare result beats first, then predict from the request beat
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        live[i]   = 1'b0;
        tab_ro[i] = 1'b0;
      end
      idle_limit    = IDLE_LIMIT_RESET;
      fail_count    = 0;
      beats_checked = 0;
      beats_reaped  = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result beat: status %0d slot %0d handle %0h",
                 out_data.status, out_data.slot_index, out_data.handle_out);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index,
                   out_data.slot_index);
            fail_count++;
          end
          if (out_data.key_out !== want.key_out) begin
            $error("key_out: expected %h, got %h", want.key_out, out_data.key_out);
            fail_count++;
          end
          if (out_data.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out,
                   out_data.handle_out);
            fail_count++;
          end
          if (out_data.read_only_out !== want.read_only_out) begin
            $error("read_only_out: expected %0d, got %0d", want.read_only_out,
                   out_data.read_only_out);
            fail_count++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_data.last_of_run);
            fail_count++;
          end
          beats_checked++;
          if (want.status == ST_REAPED) beats_reaped++;
        end
      end
      if (cfg_we) idle_limit = cfg_wdata;
      if (in_valid && !in_stall) predict_request(in_data);
    end
    pending = results_due.size();
  end

endmodule

FILE: tb/sv/session_table_with_idle_aging_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session table testbench
// Directed corner cases, then random session traffic over several idle
// limits, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module session_table_with_idle_aging_tb;
  import sess_pkg::*;

  localparam int SLOTS         = 16;
  localparam int POOL_SIZE     = 20;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 18;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  req_t        in_data;
  logic        out_valid;
  logic        out_stall;
  res_t        out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int fail_count;
  int pending;
  int beats_checked;
  int beats_reaped;

  // Stimulus state
  logic [63:0] key_pool[POOL_SIZE];
  logic [31:0] clock_s;
  logic [31:0] limits[PHASES];
  int          requests_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  session_table_with_idle_aging #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (64),
    .HANDLE_BITS(16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  session_table_with_idle_aging_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_checked(beats_checked),
    .beats_reaped (beats_reaped)
  );

  // Offer one request beat, after an optional idle burst, and wait for it
  task automatic issue_request(input logic [2:0] op, input logic [63:0] key,
                               input logic [15:0] handle, input logic ro,
                               input logic [31:0] now);
    req_t beat;
    beat.req_type       = op;
    beat.session_key    = key;
    beat.session_handle = handle;
    beat.read_only_in   = ro;
    beat.now_seconds    = now;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op <= REQ_REAP) requests_sent++;
  endtask

  // Mostly pooled keys so lookups hit; time runs forward with some noise
  task automatic random_request(input int unsigned step);
    int unsigned pick;
    logic [2:0]  op;
    logic [63:0] key;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = REQ_CREATE;
    else if (pick < 45) op = REQ_REINSERT;
    else if (pick < 70) op = REQ_LOOKUP;
    else if (pick < 88) op = REQ_REMOVE;
    else if (pick < 97) op = REQ_REAP;
    else op = REQ_REAP + 3'($urandom_range(1, 3));
    if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = {$urandom, $urandom};
    clock_s += $urandom_range(0, step);
    now = clock_s;
    case ($urandom_range(0, 19))
      0: now = $urandom;
      1: now = clock_s - 1;  // just behind recent stamps: near-full age
      default: ;
    endcase
    issue_request(op, key, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), now);
  endtask

  // Let every owed result drain, then allow a reap walk to finish
  task automatic settle_table();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_idle_limit(input logic [31:0] limit);
    cfg_we    = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result side: random stall bursts, one long hold, none in the quiet part
  initial begin : result_sink
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (hold_request && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #10_000_000;
    $display("session_table_with_idle_aging_tb failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned step;
    int          fails;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed part, under the reset idle limit
    issue_request(REQ_REAP, '0, '0, 1'b0, 32'hFFFF_FFF0);       // empty table
    issue_request(REQ_LOOKUP, key_pool[0], '0, 1'b0, 32'hFFFF_FFF0);
    issue_request(REQ_REMOVE, key_pool[0], '0, 1'b0, 32'hFFFF_FFF0);
    issue_request(REQ_CREATE, key_pool[0], 16'h0000, 1'b1, 32'hFFFF_FFF0);
    issue_request(REQ_CREATE, key_pool[1], 16'hFFFF, 1'b0, 32'hFFFF_FFF0);
    issue_request(REQ_REINSERT, key_pool[0], 16'h5A5A, 1'b0, 32'hFFFF_FFF0);
    // reinsert ignores the read-only input
    issue_request(REQ_REINSERT, key_pool[2], 16'hA5A5, 1'b1, 32'hFFFF_FFF0);
    // duplicate key through create; matches go to the lowest slot
    issue_request(REQ_CREATE, key_pool[1], 16'h1234, 1'b1, 32'hFFFF_FFF0);
    issue_request(REQ_LOOKUP, key_pool[1], '0, 1'b0, 32'hFFFF_FFF5);
    issue_request(REQ_LOOKUP, key_pool[0], '0, 1'b0, 32'h0000_0010);  // wrapped clock
    issue_request(REQ_REMOVE, key_pool[1], '0, 1'b0, 32'h0000_0010);
    issue_request(REQ_LOOKUP, key_pool[1], '0, 1'b0, 32'h0000_0010);
    for (int i = 3; i < SLOTS; i++) begin
      issue_request(REQ_CREATE, key_pool[i], 16'(i * 16'h0101), 1'(i % 2), 32'h0000_0020);
    end
    // full table: quota on create and reinsert, but existence wins
    issue_request(REQ_CREATE, key_pool[16], 16'h7777, 1'b0, 32'h0000_0020);
    issue_request(REQ_REINSERT, key_pool[16], 16'h7777, 1'b0, 32'h0000_0020);
    issue_request(REQ_REINSERT, key_pool[2], 16'h7777, 1'b0, 32'h0000_0020);
    issue_request(REQ_REAP, '0, '0, 1'b0, 32'h0000_0084);       // nothing old enough
    issue_request(REQ_REAP, '1, '1, 1'b1, 32'h0000_1000);       // every slot ages out
    issue_request(REQ_REAP + 3'd1, '1, '1, 1'b1, '1);           // unused codes
    issue_request(REQ_REAP + 3'd2, '0, '0, 1'b0, '0);
    issue_request(REQ_REAP + 3'd3, '1, '1, 1'b1, '1);

    // Random phases, each under its own idle limit
    limits[0] = 32'd40;
    limits[1] = 32'd0;
    limits[2] = 32'd1;
    limits[3] = 32'hFFFF_FFFF;
    limits[4] = 32'($urandom_range(5, 500));
    clock_s   = 32'h0000_1000;
    for (int p = 0; p < PHASES; p++) begin
      settle_table();
      write_idle_limit(limits[p]);
      quiet = (p == PHASES - 1);
      if (limits[p] <= 32'd1) step = 3;
      else if (limits[p] == 32'hFFFF_FFFF) step = 2;
      else step = limits[p] / 8 + 1;
      for (int n = 0; n < PHASE_ITEMS; ) begin
        if (p == 0 && n == 8) hold_request = 1'b1;
        random_request(step);
        if (in_data.req_type <= REQ_REAP) n++;
      end
    end

    settle_table();
    fails = fail_count;
    if (pending != 0) begin
      $error("%0d result beats never arrived", pending);
      fails++;
    end
    $display("Ran %0d requests under %0d idle-limit settings with random idling.",
             requests_sent, PHASES + 1);
    $display("Checked %0d result beats, %0d of them reaped sessions.",
             beats_checked, beats_reaped);
    if (fails == 0) begin
      $display("session_table_with_idle_aging_tb passed");
    end else begin
      $display("session_table_with_idle_aging_tb failed");
    end
    $finish;
  end

endmodule
